### rtl/salc_pkg.sv
package salc_pkg;

  localparam int AddrWidth = 64;
  localparam int CountWidth = 32;

  typedef enum logic [1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_index_t;

  localparam logic [1:0] ACT_MODIFY = 2'd2;

  typedef struct packed {
    logic             modify;
    logic [63:0]      tag;
    logic [11:0]      set;
  } req_t;

endpackage

### rtl/salc_ram.sv
module salc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/salc_front.sv
module salc_front import salc_pkg::*; #(
  parameter int MaxSetBits = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [63:0] address,
  input  logic [2:0]  set_bits,
  input  logic [5:0]  block_bits,
  output logic        q_valid,
  output req_t        q_req,
  input  logic        q_take
);

  localparam int Depth = 2;

  req_t       entry [Depth];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic [3:0] sb;
  logic [6:0] shift;
  logic [63:0] shifted;
  logic [63:0] set_mask;
  req_t       req;
  logic       push;
  logic       pop;

  always_comb begin
    sb = ({1'b0, set_bits} > 4'(MaxSetBits)) ? 4'(MaxSetBits) : {1'b0, set_bits};
    shift = {1'b0, block_bits} + {3'b0, sb};
    shifted = address >> block_bits;
    set_mask = (64'd1 << sb) - 64'd1;
    req.modify = (action == ACT_MODIFY);
    req.tag = (shift < 7'd64) ? (address >> shift) : 64'd0;
    req.set = 12'(shifted & set_mask);
  end

  assign in_stall = (count == 2'(Depth));
  assign push = in_valid && !in_stall;
  assign pop = q_take && q_valid;
  assign q_valid = (count != 2'd0);
  assign q_req = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= req;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### rtl/salc_back.sv
module salc_back import salc_pkg::*; #(
  parameter int MaxSetBits = 6,
  parameter int MaxWays = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [3:0]  ways_in_use,
  input  logic        q_valid,
  input  req_t        q_req,
  output logic        q_take,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        was_hit,
  output logic        was_miss,
  output logic        was_eviction,
  output logic [31:0] hit_total,
  output logic [31:0] miss_total,
  output logic [31:0] eviction_total
);

  localparam int NumSets = 1 << MaxSetBits;
  localparam int SetW = (MaxSetBits > 0) ? MaxSetBits : 1;
  localparam int WayW = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int EntW = AddrWidth + WayW + 1;
  localparam int RowW = MaxWays * EntW;
  localparam logic [CountWidth-1:0] CountMax = '1;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK, S_OUT} state_t;

  state_t        state;
  logic [SetW-1:0] clr_set;
  req_t          cur;
  logic [MaxWays-1:0] row_valid;
  logic          we;
  logic [SetW-1:0] waddr;
  logic [RowW-1:0] wdata;
  logic [RowW-1:0] rdata;
  logic [SetW-1:0] raddr;
  logic [AddrWidth-1:0] tags [MaxWays];
  logic [WayW-1:0] ranks [MaxWays];
  logic [AddrWidth-1:0] tags_new [MaxWays];
  logic [WayW-1:0] ranks_new [MaxWays];
  logic [4:0]    nw;
  logic          hit;
  logic          has_free;
  logic [WayW-1:0] hit_way, free_way, lru_way, sel_way;
  logic [WayW-1:0] hit_r, free_r, lru_r, sel_r;
  logic          lru_found;
  logic [31:0]   hit_cnt, miss_cnt, evict_cnt;
  logic [31:0]   hit_inc;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    return (c == CountMax) ? c : c + 32'd1;
  endfunction

  salc_ram #(.Width(RowW), .Depth(NumSets)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign raddr = SetW'(q_req.set);
  assign q_take = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    nw = (ways_in_use == 4'd0) ? 5'd1 : {1'b0, ways_in_use};
    if (nw > 5'(MaxWays)) nw = 5'(MaxWays);
    hit = 1'b0;
    has_free = 1'b0;
    lru_found = 1'b0;
    hit_way = '0;
    free_way = '0;
    lru_way = '0;
    hit_r = '0;
    free_r = '0;
    lru_r = '0;
    for (int w = 0; w < MaxWays; w++) begin
      tags[w] = rdata[w*EntW +: AddrWidth];
      ranks[w] = rdata[w*EntW+AddrWidth +: WayW];
      row_valid[w] = rdata[w*EntW+AddrWidth+WayW];
      if (5'(w) < nw) begin
        if (row_valid[w]) begin
          if (tags[w] == cur.tag && (!hit || ranks[w] < hit_r)) begin
            hit = 1'b1;
            hit_way = WayW'(w);
            hit_r = ranks[w];
          end
          if (!lru_found || ranks[w] > lru_r) begin
            lru_found = 1'b1;
            lru_way = WayW'(w);
            lru_r = ranks[w];
          end
        end else if (!has_free || ranks[w] < free_r) begin
          has_free = 1'b1;
          free_way = WayW'(w);
          free_r = ranks[w];
        end
      end
    end
    sel_way = hit ? hit_way : (has_free ? free_way : lru_way);
    sel_r = ranks[sel_way];
    for (int w = 0; w < MaxWays; w++) begin
      tags_new[w] = (WayW'(w) == sel_way) ? cur.tag : tags[w];
      if (WayW'(w) == sel_way) ranks_new[w] = '0;
      else if (ranks[w] < sel_r) ranks_new[w] = ranks[w] + WayW'(1);
      else ranks_new[w] = ranks[w];
    end
    we = 1'b0;
    waddr = SetW'(cur.set);
    wdata = '0;
    if (state == S_CLEAR) begin
      we = 1'b1;
      waddr = clr_set;
      for (int w = 0; w < MaxWays; w++) begin
        wdata[w*EntW+AddrWidth +: WayW] = WayW'(w);
      end
    end else if (state == S_LOOK) begin
      we = 1'b1;
      for (int w = 0; w < MaxWays; w++) begin
        wdata[w*EntW +: AddrWidth] = tags_new[w];
        wdata[w*EntW+AddrWidth +: WayW] = ranks_new[w];
        wdata[w*EntW+AddrWidth+WayW] = row_valid[w] | (WayW'(w) == sel_way);
      end
    end
    hit_inc = hit ? sat_inc(hit_cnt) : hit_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_set <= '0;
      hit_cnt <= '0;
      miss_cnt <= '0;
      evict_cnt <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_set <= clr_set + SetW'(1);
          if (clr_set == SetW'(NumSets - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_req;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          was_hit <= hit;
          was_miss <= !hit;
          was_eviction <= !hit && !has_free;
          hit_cnt <= cur.modify ? sat_inc(hit_inc) : hit_inc;
          if (!hit) miss_cnt <= sat_inc(miss_cnt);
          if (!hit && !has_free) evict_cnt <= sat_inc(evict_cnt);
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign hit_total = hit_cnt;
  assign miss_total = miss_cnt;
  assign eviction_total = evict_cnt;

endmodule

### rtl/set_assoc_lru_cache_tags.sv
// Each access passes the two-entry input queue, then the back end's lookup state, where
// its set row from the tag RAM is compared and written back, then its result state,
// held until out_stall is low. Only one access is looked up at a time; others queue.
// Reset: synchronous; a clearing pass over all 2**MAX_SET_BITS set rows initializes
// tags, valid bits and recency ranks, during which accesses queue but are not processed.
module set_assoc_lru_cache_tags import salc_pkg::*; #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [63:0] address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        was_hit,
  output logic        was_miss,
  output logic        was_eviction,
  output logic [31:0] hit_total,
  output logic [31:0] miss_total,
  output logic [31:0] eviction_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  logic [2:0] set_bits;
  logic [5:0] block_bits;
  logic [3:0] ways_in_use;
  logic       q_valid;
  logic       q_take;
  req_t       q_req;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits <= 3'd0;
      block_bits <= 6'd0;
      ways_in_use <= 4'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SET_BITS: set_bits <= cfg_data[2:0];
        CFG_BLOCK_BITS: block_bits <= cfg_data;
        CFG_WAYS: ways_in_use <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  salc_front #(.MaxSetBits(MAX_SET_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .address(address), .set_bits(set_bits),
    .block_bits(block_bits), .q_valid(q_valid), .q_req(q_req), .q_take(q_take)
  );

  salc_back #(.MaxSetBits(MAX_SET_BITS), .MaxWays(MAX_WAYS)) u_back (
    .clk(clk), .rst(rst), .ways_in_use(ways_in_use), .q_valid(q_valid),
    .q_req(q_req), .q_take(q_take), .out_valid(out_valid), .out_stall(out_stall),
    .was_hit(was_hit), .was_miss(was_miss), .was_eviction(was_eviction),
    .hit_total(hit_total), .miss_total(miss_total), .eviction_total(eviction_total)
  );

endmodule

### test/set_assoc_lru_cache_tags_checker.sv
module set_assoc_lru_cache_tags_checker import salc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  action,
  input  logic [63:0] address,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        was_hit,
  input  logic        was_miss,
  input  logic        was_eviction,
  input  logic [31:0] hit_total,
  input  logic [31:0] miss_total,
  input  logic [31:0] eviction_total,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumWays = 8;
  localparam int NumLines = 64 * NumWays;

  typedef struct packed {
    logic        hit;
    logic        miss;
    logic        evict;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evicts;
  } outcome_t;

  logic [63:0] tag_mem [NumLines];
  logic        valid_mem [NumLines];
  logic [2:0]  rank_mem [NumLines];
  logic [31:0] hits_q, misses_q, evicts_q;
  logic [2:0]  set_bits_q;
  logic [5:0]  block_bits_q;
  logic [3:0]  ways_q;
  outcome_t    outcome_q [$];

  function automatic logic [31:0] bump(logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  task automatic promote(int base, int way);
    logic [2:0] r;
    r = rank_mem[base + way];
    for (int w = 0; w < NumWays; w++) begin
      if (rank_mem[base + w] < r) rank_mem[base + w] = rank_mem[base + w] + 3'd1;
    end
    rank_mem[base + way] = 3'd0;
  endtask

  task automatic lookup_access(logic [1:0] act, logic [63:0] addr);
    int sb, nw, shift, base, hw, fw, lw, idx;
    logic [63:0] tg;
    outcome_t o;
    sb = (set_bits_q > 6) ? 6 : set_bits_q;
    nw = (ways_q < 1) ? 1 : ((ways_q > NumWays) ? NumWays : ways_q);
    shift = block_bits_q + sb;
    tg = (shift < 64) ? (addr >> shift) : 64'd0;
    base = int'((addr >> block_bits_q) & ((64'd1 << sb) - 1)) * NumWays;
    hw = -1;
    fw = -1;
    lw = -1;
    o = '0;
    for (int w = 0; w < nw; w++) begin
      idx = base + w;
      if (valid_mem[idx]) begin
        if (tag_mem[idx] == tg && (hw < 0 || rank_mem[idx] < rank_mem[base + hw])) hw = w;
        if (lw < 0 || rank_mem[idx] > rank_mem[base + lw]) lw = w;
      end else if (fw < 0 || rank_mem[idx] < rank_mem[base + fw]) begin
        fw = w;
      end
    end
    if (hw >= 0) begin
      o.hit = 1'b1;
      hits_q = bump(hits_q);
      promote(base, hw);
    end else if (fw >= 0) begin
      o.miss = 1'b1;
      misses_q = bump(misses_q);
      valid_mem[base + fw] = 1'b1;
      tag_mem[base + fw] = tg;
      promote(base, fw);
    end else begin
      o.miss = 1'b1;
      o.evict = 1'b1;
      misses_q = bump(misses_q);
      evicts_q = bump(evicts_q);
      if (lw < 0) lw = 0;
      tag_mem[base + lw] = tg;
      promote(base, lw);
    end
    if (act == ACT_MODIFY) hits_q = bump(hits_q);
    o.hits = hits_q;
    o.misses = misses_q;
    o.evicts = evicts_q;
    outcome_q.push_back(o);
  endtask

  assign pending = outcome_q.size();

  always @(posedge clk) begin
    outcome_t e;
    int errs;
    if (rst) begin
      for (int i = 0; i < NumLines; i++) begin
        tag_mem[i] <= '0;
        valid_mem[i] <= 1'b0;
        rank_mem[i] <= 3'(i % NumWays);
      end
      hits_q <= '0;
      misses_q <= '0;
      evicts_q <= '0;
      set_bits_q <= '0;
      block_bits_q <= '0;
      ways_q <= 4'd1;
      outcome_q.delete();
      fail_count <= 0;
    end else begin
      errs = 0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SET_BITS: set_bits_q = cfg_data[2:0];
          CFG_BLOCK_BITS: block_bits_q = cfg_data;
          CFG_WAYS: ways_q = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) lookup_access(action, address);
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $error("result transfer with no access outstanding");
          errs++;
        end else begin
          e = outcome_q.pop_front();
          if (was_hit !== e.hit) begin
            $error("was_hit expected %0d got %0d", e.hit, was_hit);
            errs++;
          end
          if (was_miss !== e.miss) begin
            $error("was_miss expected %0d got %0d", e.miss, was_miss);
            errs++;
          end
          if (was_eviction !== e.evict) begin
            $error("was_eviction expected %0d got %0d", e.evict, was_eviction);
            errs++;
          end
          if (hit_total !== e.hits) begin
            $error("hit_total expected %0d got %0d", e.hits, hit_total);
            errs++;
          end
          if (miss_total !== e.misses) begin
            $error("miss_total expected %0d got %0d", e.misses, miss_total);
            errs++;
          end
          if (eviction_total !== e.evicts) begin
            $error("eviction_total expected %0d got %0d", e.evicts, eviction_total);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

### test/set_assoc_lru_cache_tags_test.sv
module set_assoc_lru_cache_tags_test import salc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk, rst;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic [1:0]  action;
  logic [63:0] address;
  logic        was_hit, was_miss, was_eviction;
  logic [31:0] hit_total, miss_total, eviction_total;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [5:0]  cfg_data;
  int          fail_count, pending;
  int          cycle_count;
  int          stall_left;
  bit          stall_free;

  set_assoc_lru_cache_tags uut (.*);

  set_assoc_lru_cache_tags_checker checker_inst (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 1000000) begin
        $display("set_assoc_lru_cache_tags verification failed");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (rst || stall_free) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 30) begin
      out_stall <= 1'b1;
      stall_left <= gap_len();
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_access(logic [1:0] act, logic [63:0] addr);
    int g;
    g = stall_free ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    address <= addr;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [5:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_setting(logic [5:0] sb, logic [5:0] bb, logic [5:0] nw);
    drain();
    write_reg(CFG_SET_BITS, sb);
    write_reg(CFG_BLOCK_BITS, bb);
    write_reg(CFG_WAYS, nw);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [1:0] rand_act();
    return ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
  endfunction

  initial begin
    logic [63:0] pool [8];
    rst = 1'b1;
    in_valid = 1'b0;
    action = '0;
    address = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SET_BITS;
    cfg_data = '0;
    stall_free = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_access(2'd0, 64'd0);
    send_access(2'd0, 64'd0);
    send_access(ACT_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(2'd3, 64'h5555_5555_5555_5555);
    send_access(2'd1, 64'hAAAA_AAAA_AAAA_AAAA);
    apply_setting(6'd2, 6'd4, 6'd2);
    for (int i = 0; i < 5; i++) send_access(2'(i % 3), 64'(i) << 6);
    send_access(2'd1, 64'd0);
    apply_setting(6'd7, 6'd58, 6'd0);
    send_access(2'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(ACT_MODIFY, 64'h0123_4567_89AB_CDEF);
    apply_setting(6'd6, 6'd0, 6'd15);
    for (int i = 0; i < 10; i++) send_access(2'd0, 64'(i) << 6);
    send_access(ACT_MODIFY, 64'd0);
    apply_setting(6'd0, 6'd63, 6'd8);
    send_access(2'd0, 64'h8000_0000_0000_0000);
    send_access(2'd1, 64'd1);

    stall_free = 1'b1;
    drain();
    stall_free = 1'b0;

    for (int phase = 0; phase < 8; phase++) begin
      apply_setting(6'($urandom_range(0, 7)), 6'($urandom_range(0, 12)),
                    6'($urandom_range(0, 9)));
      if (phase == 7) apply_setting(6'd6, 6'($urandom_range(0, 63)), 6'd8);
      for (int k = 0; k < 8; k++) pool[k] = rand64();
      stall_free = (phase == 3);
      for (int n = 0; n < 180; n++) begin
        if ($urandom_range(0, 9) < 7) send_access(rand_act(), pool[$urandom_range(0, 7)]);
        else send_access(rand_act(), rand64());
      end
      stall_free = 1'b0;
    end

    stall_free = 1'b1;
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("set_assoc_lru_cache_tags verification clean");
    else $display("set_assoc_lru_cache_tags verification failed");
    $finish;
  end
endmodule

### set_assoc_lru_cache_tags.f
rtl/salc_pkg.sv
rtl/salc_ram.sv
rtl/salc_front.sv
rtl/salc_back.sv
rtl/set_assoc_lru_cache_tags.sv
test/set_assoc_lru_cache_tags_checker.sv
test/set_assoc_lru_cache_tags_test.sv
